@@ rtl/core/adtp_pkg.sv @@
// Package for the thermistor ADC to temperature pipeline.
// Holds the stage word type and the fixed polynomial constants; no dependencies.
package adtp_pkg;

    localparam int unsigned SAMPLE_W = 11;
    localparam int unsigned X_W      = 11;
    localparam int unsigned P_W      = 17;
    localparam int unsigned ACC_W    = 26;
    localparam int unsigned TEMP_W   = 19;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned NSTAGE   = 5;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 11'd1536;
    localparam logic [SAMPLE_W:0]   SAMPLE_BIAS = 12'd555;
    // p1 = (x * 2^17) >> 11 is exactly x * 64
    localparam int unsigned P1_SHIFT    = 6;
    localparam int unsigned POWER_SHIFT = 11;
    localparam int unsigned OUT_SHIFT   = 4;
    // constant term: (55548 * (2^17 >> 8)) >> 5
    localparam logic signed [ACC_W-1:0] ACC_SEED = 26'sd888768;

    // coefficients already shifted right by k/2, and the term shift 5 - k/2
    localparam logic signed [COEF_W-1:0] STAGE_COEF [1:NSTAGE] = '{
        -16'sd647, -16'sd118, -16'sd570, 16'sd8515, -16'sd27767
    };
    localparam logic [2:0] TERM_SHIFT [1:NSTAGE] = '{3'd5, 3'd4, 3'd4, 3'd3, 3'd3};

    typedef struct packed {
        logic                    valid;
        logic signed [X_W-1:0]   x;
        logic signed [P_W-1:0]   p;
        logic signed [ACC_W-1:0] acc;
    } t_stage;

endpackage

@@ rtl/core/adtp_if.sv @@
// Valid/ready channel interfaces for the ADC sample and temperature words.
// Depends on adtp_pkg for field widths.
interface adtp_in_if;
    logic                             valid;
    logic                             ready;
    logic [adtp_pkg::SAMPLE_W-1:0]    adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface adtp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [adtp_pkg::TEMP_W-1:0]   temperature_milli_c;

    modport source (output valid, output temperature_milli_c, input ready);
    modport sink   (input valid, input temperature_milli_c, output ready);
endinterface

@@ rtl/core/adtp_stage.sv @@
// One pipeline stage: next scaled power of x and one accumulated polynomial term.
// Depends on adtp_pkg (t_stage, widths).
module adtp_stage (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [adtp_pkg::COEF_W-1:0]    i_coef,
    input  logic [2:0]                            i_term_shift,
    input  adtp_pkg::t_stage                      i_up,
    output logic                                  o_up_ready,
    output adtp_pkg::t_stage                      o_dn,
    input  logic                                  i_dn_ready
);
    localparam int unsigned PPROD_W = adtp_pkg::X_W + adtp_pkg::P_W;
    localparam int unsigned TPROD_W = adtp_pkg::COEF_W + adtp_pkg::P_W;

    adtp_pkg::t_stage           r_dn;
    adtp_pkg::t_stage           n_dn;
    logic signed [PPROD_W-1:0]  w_pprod;
    logic signed [TPROD_W-1:0]  w_tprod;
    logic signed [TPROD_W-1:0]  w_term;

    assign o_up_ready = !r_dn.valid || i_dn_ready;
    assign o_dn       = r_dn;

    always_comb begin
        w_pprod = PPROD_W'(i_up.x) * PPROD_W'(i_up.p);
        w_tprod = TPROD_W'(i_coef) * TPROD_W'(i_up.p);
        w_term  = w_tprod >>> i_term_shift;
        n_dn.valid = i_up.valid;
        n_dn.x     = i_up.x;
        n_dn.p     = adtp_pkg::P_W'(w_pprod >>> adtp_pkg::POWER_SHIFT);
        n_dn.acc   = i_up.acc + adtp_pkg::ACC_W'(w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn.valid <= 1'b0;
        end else if (o_up_ready) begin
            r_dn <= n_dn;
        end
    end

endmodule

@@ rtl/core/adc_to_temperature_polynomial_top.sv @@
// Thermistor ADC code to temperature (millidegrees C), fifth-order polynomial.
// Depends on adtp_pkg, adtp_if (adtp_in_if, adtp_out_if) and adtp_stage.
//
// Usage:
//   i_sample carries one raw 11-bit ADC code per word; o_temp carries one
//   signed 19-bit temperature per word. Every input word gives exactly one
//   output word, in order.
//   The sample is clamped to 1536, biased by -555, and run through an input
//   register, five multiply stages (each builds the next power of x and adds
//   one term) and an output register.
//   Throughput: one word per cycle while the receiver holds o_temp.ready
//   high; every register in the pipeline holds one word.
//   Each stage has its own valid bit and advances when it is empty or its
//   successor takes its word, so a stalled receiver fills the pipeline
//   bubble by bubble; i_sample.ready drops only when every stage is full.
//   Reset (synchronous, active low) empties all stages; no word is lost or
//   repeated across a stall.
module adc_to_temperature_polynomial_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adtp_in_if.sink     i_sample,
    adtp_out_if.source  o_temp
);
    localparam int unsigned NSTAGE = adtp_pkg::NSTAGE;

    adtp_pkg::t_stage                       r_s0;
    adtp_pkg::t_stage                       n_s0;
    adtp_pkg::t_stage                       w_s   [0:NSTAGE];
    logic                                   w_rdy [0:NSTAGE];
    logic [adtp_pkg::SAMPLE_W-1:0]          w_clamped;
    logic signed [adtp_pkg::SAMPLE_W:0]     w_x;
    logic                                   r_out_valid;
    logic signed [adtp_pkg::TEMP_W-1:0]     r_out_temp;
    logic                                   w_s0_ready;

    // input stage: clamp, bias, first power
    always_comb begin
        w_clamped  = (i_sample.adc_sample > adtp_pkg::SAMPLE_MAX) ?
                     adtp_pkg::SAMPLE_MAX : i_sample.adc_sample;
        w_x        = $signed({1'b0, w_clamped}) - $signed(adtp_pkg::SAMPLE_BIAS);
        n_s0.valid = i_sample.valid;
        n_s0.x     = adtp_pkg::X_W'(w_x);
        n_s0.p     = adtp_pkg::P_W'(w_x) <<< adtp_pkg::P1_SHIFT;
        n_s0.acc   = adtp_pkg::ACC_SEED;
    end

    assign w_s0_ready     = !r_s0.valid || w_rdy[0];
    assign i_sample.ready = w_s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_s0_ready) begin
            r_s0 <= n_s0;
        end
    end

    assign w_s[0] = r_s0;

    for (genvar k = 1; k <= NSTAGE; k++) begin : g_stage
        adtp_stage u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_coef       (adtp_pkg::STAGE_COEF[k]),
            .i_term_shift (adtp_pkg::TERM_SHIFT[k]),
            .i_up         (w_s[k-1]),
            .o_up_ready   (w_rdy[k-1]),
            .o_dn         (w_s[k]),
            .i_dn_ready   (w_rdy[k])
        );
    end

    // output register
    assign w_rdy[NSTAGE] = !r_out_valid || o_temp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[NSTAGE]) begin
            r_out_valid <= w_s[NSTAGE].valid;
            r_out_temp  <= adtp_pkg::TEMP_W'(w_s[NSTAGE].acc >>> adtp_pkg::OUT_SHIFT);
        end
    end

    assign o_temp.valid               = r_out_valid;
    assign o_temp.temperature_milli_c = r_out_temp;

    // a free-running receiver never backs up into the input
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_temp.ready |-> i_sample.ready)
        else $error("input stalled while receiver ready");

    // an accepted word lands in the input stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> r_s0.valid)
        else $error("accepted word not captured");

    // codes above range clamp to the top of the curve
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready && (i_sample.adc_sample >= adtp_pkg::SAMPLE_MAX))
        |=> (r_s0.x == 11'sd981))
        else $error("sample clamp failed");

endmodule

@@ sim/tb_adc_to_temperature_polynomial_top.sv @@
`timescale 1ns / 100ps
// Testbench for adc_to_temperature_polynomial_top: ADC code in, millidegrees C out.
// Uses adtp_pkg and the adtp_in_if / adtp_out_if channels from the RTL.
module tb_adc_to_temperature_polynomial_top;

    localparam longint POLY_COEF [6] = '{55548, -647, -236, -1140, 34060, -111066};
    localparam longint CODE_OFFSET   = 555;
    localparam int     RANDOM_WORDS  = 450;
    localparam int     REPORT_LIMIT  = 10;

    // range ends, clamp boundary, offset point, single bits and alternating bits
    localparam logic [adtp_pkg::SAMPLE_W-1:0] EDGE_CODES [16] = '{
        11'd0, 11'd1, 11'd2047, 11'd1536, 11'd1535, 11'd1537, 11'd555, 11'd554,
        11'd556, 11'h400, 11'h555, 11'h2AA, 11'h7FE, 11'd1024, 11'd100, 11'd1200
    };

    class temp_scoreboard;
        logic signed [adtp_pkg::TEMP_W-1:0] expected_temps [$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        // fifth-order polynomial with scaled powers; >>> on longint is a floor shift
        function logic signed [adtp_pkg::TEMP_W-1:0] poly_temperature(
            logic [adtp_pkg::SAMPLE_W-1:0] code
        );
            longint x;
            longint pw;
            longint sum;
            int     r;
            x   = ((code > adtp_pkg::SAMPLE_MAX) ? longint'(adtp_pkg::SAMPLE_MAX)
                                                  : longint'(code)) - CODE_OFFSET;
            pw  = longint'(1) << 17;
            sum = (POLY_COEF[0] * (pw >>> 8)) >>> 5;
            for (int k = 1; k < 6; k++) begin
                pw  = (x * pw) >>> 11;
                r   = k / 2;
                sum += ((POLY_COEF[k] >>> r) * pw) >>> (5 - r);
            end
            sum = sum >>> 4;
            return sum[adtp_pkg::TEMP_W-1:0];
        endfunction

        function void note_sample(logic [adtp_pkg::SAMPLE_W-1:0] code);
            expected_temps.push_back(poly_temperature(code));
        endfunction

        function void check_temperature(logic signed [adtp_pkg::TEMP_W-1:0] temp);
            logic signed [adtp_pkg::TEMP_W-1:0] want;
            if (expected_temps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected temperature word %0d at %0t", temp, $time);
                return;
            end
            want = expected_temps.pop_front();
            if (temp !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("temperature mismatch at %0t: expected %0d, got %0d",
                             $time, want, temp);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    adtp_in_if  sample_ch ();
    adtp_out_if temp_ch ();

    adc_to_temperature_polynomial_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_temp   (temp_ch.source)
    );

    temp_scoreboard temps = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input logic [adtp_pkg::SAMPLE_W-1:0] code);
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= code;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        temps.note_sample(code);
    endtask

    // call only with cycles > 0, so valid is never lowered and raised in one step
    task automatic pause_sender(input int cycles);
        sample_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [adtp_pkg::SAMPLE_W-1:0] random_code();
        // mostly in the linear range, the rest above the clamp
        if ($urandom_range(0, 99) < 85)
            return adtp_pkg::SAMPLE_W'($urandom_range(0, int'(adtp_pkg::SAMPLE_MAX)));
        return adtp_pkg::SAMPLE_W'($urandom_range(int'(adtp_pkg::SAMPLE_MAX) + 1, 2047));
    endfunction

    // receiver: cycles through always-ready, short random stalls and long stalls
    initial begin
        int cyc;
        int stall_left;
        cyc        = 0;
        stall_left = 0;
        temp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (stall_left > 0) begin
                temp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                temp_ch.ready <= 1'b1;
                case ((cyc / 150) % 3)
                    1: begin
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 3);
                    end
                    2: begin
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(5, 30);
                    end
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && temp_ch.valid && temp_ch.ready)
            temps.check_temperature(temp_ch.temperature_milli_c);
    end

    initial begin
        int left;
        int burst;
        int gap;
        sample_ch.valid      <= 1'b0;
        sample_ch.adc_sample <= '0;
        i_rst_n              <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (EDGE_CODES[i])
            send_word(EDGE_CODES[i]);
        pause_sender(3);

        left = RANDOM_WORDS;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst) send_word(random_code());
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                pause_sender(gap);
        end
        pause_sender(1);

        while (temps.expected_temps.size() != 0) @(posedge i_clk);
        // leave room for any stray word from the pipeline
        repeat (20) @(posedge i_clk);

        if (temps.mismatches == 0 && temps.expected_temps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
